@@ src/ccss_pkg.sv @@
// Shared types, constants and codes for the character class store.
`timescale 1ns / 1ps
package ccss_pkg;

	// Default sizes
	localparam int MAX_CLASSES_DEF = 64;
	localparam int TABLE_DEPTH_DEF = 1024;

	// Field widths
	localparam int OP_W  = 2;
	localparam int ID_W  = 7;
	localparam int CH_W  = 8;
	localparam int LEN_W = 9;
	localparam int STS_W = 3;

	// Operation codes
	localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OP_W-1:0] OP_NEGATE = 2'd2;

	// Status codes
	localparam logic [STS_W-1:0] STS_OK      = 3'd0;
	localparam logic [STS_W-1:0] STS_PRESENT = 3'd1;
	localparam logic [STS_W-1:0] STS_FULL    = 3'd2;
	localparam logic [STS_W-1:0] STS_MANY    = 3'd3;
	localparam logic [STS_W-1:0] STS_BAD     = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [ID_W-1:0] class_id;
		logic [CH_W-1:0] char_code;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]  result_class;
		logic [LEN_W-1:0] class_length;
		logic             class_negated;
		logic [STS_W-1:0] status;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_SCAN,
		S_FINISH
	} ccss_state_t;

	// Controller to datapath
	typedef struct packed {
		logic latch_req;
		logic info_rd;
		logic decide;
		logic scan_step;
		logic add_finish;
		logic load_out;
	} ccss_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic add_newest;
		logic scan_hit;
		logic scan_end;
		logic out_free;
	} ccss_sts_t;

endpackage

@@ src/char_class_set_store_unit.sv @@
// Character class store: controller plus datapath, one item at a time.
// Create, negate and rejected items pass through the decode, read and finish states;
// an add to the newest class also runs the duplicate scan between read and finish,
//   reading one stored character per cycle until a match or the end of the class.
// The next item is accepted in the cycle after the result is loaded.
// Reset: arst_n clears class count and control; tables need no clearing.
`timescale 1ns / 1ps
module char_class_set_store_unit #(
	parameter int MAX_CLASSES = ccss_pkg::MAX_CLASSES_DEF,
	parameter int TABLE_DEPTH = ccss_pkg::TABLE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ccss_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ccss_pkg::rsp_t rsp
);
	import ccss_pkg::*;

	ccss_cmd_t cmd;
	ccss_sts_t sts;

	ccss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ccss_dp #(
		.MAX_CLASSES(MAX_CLASSES),
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.rsp      (rsp),
		.rsp_valid(rsp_valid)
	);

endmodule

@@ src/ccss_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ccss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/ccss_ctrl.sv @@
// Controller state machine: sequences decode, table lookup, scan and result.
`timescale 1ns / 1ps
module ccss_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  ccss_pkg::ccss_sts_t   sts,
	output ccss_pkg::ccss_cmd_t   cmd
);
	import ccss_pkg::*;

	ccss_state_t state_q;
	ccss_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch_req = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.info_rd = 1'b1;
				state_d     = S_READ;
			end
			S_READ: begin
				cmd.decide = 1'b1;
				state_d    = sts.add_newest ? S_SCAN : S_FINISH;
			end
			S_SCAN: begin
				if (sts.scan_hit || sts.scan_end) begin
					cmd.add_finish = 1'b1;
					state_d        = S_FINISH;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ src/ccss_dp.sv @@
// Datapath: class registers, class info and character RAMs, scan and result.
`timescale 1ns / 1ps
module ccss_dp #(
	parameter int MAX_CLASSES = ccss_pkg::MAX_CLASSES_DEF,
	parameter int TABLE_DEPTH = ccss_pkg::TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ccss_pkg::req_t      req,
	input  ccss_pkg::ccss_cmd_t cmd,
	input  logic                rsp_stall,
	output ccss_pkg::ccss_sts_t sts,
	output ccss_pkg::rsp_t      rsp,
	output logic                rsp_valid
);
	import ccss_pkg::*;

	localparam int CW     = $clog2(MAX_CLASSES + 1);
	localparam int IW     = $clog2(MAX_CLASSES);
	localparam int SW     = $clog2(TABLE_DEPTH + 1);
	localparam int AW     = $clog2(TABLE_DEPTH);
	localparam int KW     = (CW > ID_W) ? CW : ID_W;
	localparam int INFO_W = LEN_W + 1;

	req_t             req_q;
	logic [CW-1:0]    count_q;
	logic [SW-1:0]    top_start_q;
	logic [LEN_W-1:0] top_len_q;
	logic [LEN_W-1:0] scan_idx_q;
	logic             pend_q;
	logic             neg_q;
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	logic [KW-1:0]     id_k;
	logic [KW-1:0]     cnt_k;
	logic              id_bad;
	logic              is_newest;
	logic              too_many;
	logic [IW-1:0]     info_idx;
	logic [SW:0]       end_sum;
	logic              table_full;
	logic              hit;
	logic              scan_end;
	logic              append;
	logic              create_ok;
	logic              add_newest;
	logic [SW-1:0]     scan_pos;

	logic              info_wr_en;
	logic [IW-1:0]     info_wr_addr;
	logic [INFO_W-1:0] info_wr_data;
	logic [INFO_W-1:0] info_rd_data;
	logic [LEN_W-1:0]  info_len;
	logic              info_neg;
	logic [CH_W-1:0]   char_rd_data;
	rsp_t              res_d;

	// Decode of the held item against the class count
	assign id_k       = KW'(req_q.class_id);
	assign cnt_k      = KW'(count_q);
	assign id_bad     = (req_q.class_id == '0) || (id_k > cnt_k);
	assign is_newest  = (id_k == cnt_k);
	assign too_many   = (count_q >= CW'(MAX_CLASSES));
	assign info_idx   = IW'(id_k - KW'(1));
	assign add_newest = (req_q.op == OP_ADD) && !id_bad && is_newest;
	assign create_ok  = (req_q.op == OP_CREATE) && !too_many;

	assign info_len = info_rd_data[LEN_W-1:0];
	assign info_neg = info_rd_data[LEN_W];

	// End of the newest class and duplicate scan
	assign end_sum    = (SW+1)'(top_start_q) + (SW+1)'(top_len_q);
	assign table_full = (end_sum >= (SW+1)'(TABLE_DEPTH));
	assign hit        = pend_q && (char_rd_data == req_q.char_code);
	assign scan_end   = (scan_idx_q == top_len_q);
	assign scan_pos   = top_start_q + SW'(scan_idx_q);
	assign append     = cmd.add_finish && !hit && !table_full;

	assign sts.add_newest = add_newest;
	assign sts.scan_hit   = hit;
	assign sts.scan_end   = scan_end;
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;

	// Class info write: create, negate, append
	always_comb begin
		info_wr_en   = 1'b0;
		info_wr_addr = info_idx;
		info_wr_data = '0;
		if (cmd.decide && create_ok) begin
			info_wr_en   = 1'b1;
			info_wr_addr = IW'(count_q);
			info_wr_data = '0;
		end else if (cmd.decide && (req_q.op == OP_NEGATE) && !id_bad) begin
			info_wr_en   = 1'b1;
			info_wr_data = {1'b1, info_len};
		end else if (append) begin
			info_wr_en   = 1'b1;
			info_wr_data = {neg_q, top_len_q + LEN_W'(1)};
		end
	end

	// Result of the current item
	always_comb begin
		res_d = '{result_class: '0, class_length: '0, class_negated: 1'b0,
			status: STS_BAD};
		if (cmd.add_finish) begin
			res_d.result_class  = req_q.class_id;
			res_d.class_negated = neg_q;
			if (hit) begin
				res_d.class_length = top_len_q;
				res_d.status       = STS_PRESENT;
			end else if (table_full) begin
				res_d.class_length = top_len_q;
				res_d.status       = STS_FULL;
			end else begin
				res_d.class_length = top_len_q + LEN_W'(1);
				res_d.status       = STS_OK;
			end
		end else begin
			case (req_q.op)
				OP_CREATE: begin
					if (too_many) begin
						res_d.status = STS_MANY;
					end else begin
						res_d.result_class = ID_W'(count_q + CW'(1));
						res_d.status       = STS_OK;
					end
				end
				OP_NEGATE: begin
					if (!id_bad) begin
						res_d.result_class  = req_q.class_id;
						res_d.class_length  = info_len;
						res_d.class_negated = 1'b1;
						res_d.status        = STS_OK;
					end
				end
				OP_ADD: begin
					// older class may not grow
					if (!id_bad && !is_newest) begin
						res_d.result_class  = req_q.class_id;
						res_d.class_length  = info_len;
						res_d.class_negated = info_neg;
						res_d.status        = STS_BAD;
					end
				end
				default: begin
					res_d.status = STS_BAD;
				end
			endcase
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_q <= cmd.scan_step;
			if (cmd.decide && create_ok) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q <= req;
		end
		if (cmd.decide) begin
			res_q      <= res_d;
			neg_q      <= info_neg;
			scan_idx_q <= '0;
			if (create_ok) begin
				top_start_q <= (count_q == '0) ? '0 : SW'(end_sum);
				top_len_q   <= '0;
			end
		end
		if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + LEN_W'(1);
		end
		if (cmd.add_finish) begin
			res_q <= res_d;
			if (append) begin
				top_len_q <= top_len_q + LEN_W'(1);
			end
		end
		if (cmd.load_out) begin
			rsp_q <= res_q;
		end
	end

	// Length and negation of every class
	ccss_ram #(
		.WIDTH(INFO_W),
		.DEPTH(MAX_CLASSES)
	) u_info_ram (
		.clk    (clk),
		.wr_en  (info_wr_en),
		.wr_addr(info_wr_addr),
		.wr_data(info_wr_data),
		.rd_en  (cmd.info_rd),
		.rd_addr(info_idx),
		.rd_data(info_rd_data)
	);

	// Shared character table
	ccss_ram #(
		.WIDTH(CH_W),
		.DEPTH(TABLE_DEPTH)
	) u_char_ram (
		.clk    (clk),
		.wr_en  (append),
		.wr_addr(AW'(end_sum)),
		.wr_data(req_q.char_code),
		.rd_en  (cmd.scan_step),
		.rd_addr(AW'(scan_pos)),
		.rd_data(char_rd_data)
	);

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

@@ src/ccss_chk.sv @@
// Port-level checker for the character class store, bound to the top level.
`timescale 1ns / 1ps
module ccss_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input ccss_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input ccss_pkg::rsp_t rsp
);
	import ccss_pkg::*;

	// One item in flight: the cycle after an accept is stalled
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("item accepted while previous item in work");

	// Stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// Too many classes reports no class
	a_many_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STS_MANY) |->
		(rsp.result_class == '0) && (rsp.class_length == '0) && !rsp.class_negated)
		else $error("too-many result names a class");

	// A duplicate implies a non-empty, real class
	a_present: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == STS_PRESENT) |->
		(rsp.result_class != '0) && (rsp.class_length != '0))
		else $error("duplicate reported in empty class");

endmodule

bind char_class_set_store_unit ccss_chk u_ccss_chk (.*);

@@ dv/char_class_set_store_unit_tb.sv @@
// Self-checking testbench for the character class store unit.
`timescale 1ns / 1ps
module char_class_set_store_unit_tb;
	import ccss_pkg::*;

	localparam int MAX_CLS      = MAX_CLASSES_DEF;
	localparam int DEPTH        = TABLE_DEPTH_DEF;
	localparam int CHARS        = 256;
	localparam int CREATE_CAP   = 40;
	localparam int RANDOM_ITEMS = 165;
	// long enough for two full-length scans to finish behind a held result
	localparam int HOLD_CYCLES  = 1200;
	localparam int DRAIN_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 1500000;
	// op code the block does not define
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// predicted store contents
	int unsigned     n_classes = 0;
	int unsigned     cls_start [MAX_CLS];
	int unsigned     cls_len [MAX_CLS];
	bit              cls_neg [MAX_CLS];
	logic [CH_W-1:0] char_mem [DEPTH];

	rsp_t   class_result_q [$];
	int     error_count     = 0;
	int     items_sent      = 0;
	int     results_checked = 0;
	int     status_seen [8];
	longint cycle_count     = 0;
	int     tx_idle_pct     = 0;
	int     rx_stall_pct    = 0;
	logic   hold_on         = 1'b0;
	event   hold_kick;

	char_class_set_store_unit #(
		.MAX_CLASSES(MAX_CLS),
		.TABLE_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run time guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Describe class id as it stands, with the given status
	function automatic rsp_t class_report(int unsigned id, logic [STS_W-1:0] st);
		rsp_t o;
		o.result_class  = ID_W'(id);
		o.class_length  = LEN_W'(cls_len[id-1]);
		o.class_negated = cls_neg[id-1];
		o.status        = st;
		return o;
	endfunction

	// Apply one item to the predicted store and return its result
	function automatic rsp_t predict_class_result(req_t r);
		rsp_t o;
		int unsigned id, base, len, slot;
		o  = '0;
		id = r.class_id;
		if (r.op == OP_CREATE) begin
			if (n_classes >= MAX_CLS) begin
				o.status = STS_MANY;
				return o;
			end
			slot = n_classes;
			cls_start[slot] = (slot == 0) ? 0 : cls_start[slot-1] + cls_len[slot-1];
			cls_len[slot]   = 0;
			cls_neg[slot]   = 1'b0;
			n_classes       = slot + 1;
			return class_report(n_classes, STS_OK);
		end
		// unused op or class out of range
		if (r.op == OP_UNUSED || id == 0 || id > n_classes) begin
			o.status = STS_BAD;
			return o;
		end
		if (r.op == OP_NEGATE) begin
			cls_neg[id-1] = 1'b1;
			return class_report(id, STS_OK);
		end
		// only the newest class may grow
		if (id != n_classes)
			return class_report(id, STS_BAD);
		base = cls_start[id-1];
		len  = cls_len[id-1];
		for (int i = 0; i < len; i++)
			if (base + i < DEPTH && char_mem[base+i] == r.char_code)
				return class_report(id, STS_PRESENT);
		if (base + len >= DEPTH)
			return class_report(id, STS_FULL);
		char_mem[base+len] = r.char_code;
		cls_len[id-1]      = len + 1;
		return class_report(id, STS_OK);
	endfunction

	function automatic req_t class_req(logic [OP_W-1:0] op, int unsigned id, int unsigned ch);
		req_t r;
		r.op        = op;
		r.class_id  = ID_W'(id);
		r.char_code = CH_W'(ch);
		return r;
	endfunction

	// Offer one item, wait for its acceptance, record the expected result
	task automatic send_class_op(input req_t item);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		req       <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		class_result_q.push_back(predict_class_result(item));
		items_sent++;
	endtask

	// Stop offering and let every outstanding result come back
	task automatic drain_results();
		req_valid <= 1'b0;
		while (class_result_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Result checker and receiver stall
	always @(posedge clk) begin : result_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_checked++;
			if (class_result_q.size() == 0) begin
				$error("result with nothing expected: class %0d status %0d",
					rsp.result_class, rsp.status);
				error_count++;
			end else begin
				want = class_result_q.pop_front();
				status_seen[want.status]++;
				if (rsp.result_class !== want.result_class) begin
					$error("result_class: expected %0d, actual %0d",
						want.result_class, rsp.result_class);
					error_count++;
				end
				if (rsp.class_length !== want.class_length) begin
					$error("class_length: expected %0d, actual %0d",
						want.class_length, rsp.class_length);
					error_count++;
				end
				if (rsp.class_negated !== want.class_negated) begin
					$error("class_negated: expected %0d, actual %0d",
						want.class_negated, rsp.class_negated);
					error_count++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					error_count++;
				end
			end
		end
		rsp_stall <= hold_on || ($urandom_range(0, 99) < rx_stall_pct);
	end

	// Long receiver hold-off, counted here
	initial forever begin
		@hold_kick;
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	// Everything before the first create is out of range
	task automatic test_empty_store();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		send_class_op(class_req(OP_NEGATE, 1, 0));
		send_class_op(class_req(OP_ADD, 1, 8'h41));
		send_class_op(class_req(OP_ADD, 0, 8'hFF));
		send_class_op(class_req(OP_UNUSED, 127, 8'hFF));
		send_class_op(class_req(OP_ADD, 127, 8'h00));
		drain_results();
	endtask

	// Every operation and the simple corner cases
	task automatic test_basic_ops();
		send_class_op(class_req(OP_CREATE, 0, 0));
		send_class_op(class_req(OP_ADD, 1, 8'h00));
		send_class_op(class_req(OP_ADD, 1, 8'hFF));
		send_class_op(class_req(OP_ADD, 1, 8'h00));
		send_class_op(class_req(OP_ADD, 1, 8'hFF));
		send_class_op(class_req(OP_NEGATE, 1, 0));
		// negate again: stays negated
		send_class_op(class_req(OP_NEGATE, 1, 0));
		send_class_op(class_req(OP_ADD, 1, 8'h80));
		send_class_op(class_req(OP_CREATE, 127, 8'hFF));
		// older class may not grow
		send_class_op(class_req(OP_ADD, 1, 8'h41));
		send_class_op(class_req(OP_ADD, 2, 8'h41));
		send_class_op(class_req(OP_NEGATE, 3, 0));
		send_class_op(class_req(OP_ADD, 0, 8'h41));
		send_class_op(class_req(OP_UNUSED, 2, 8'h41));
		drain_results();
	endtask

	// Mostly adds to the newest class, some creates, negates and noise
	task automatic test_random_traffic(int tx_pct, int rx_pct);
		int unsigned     pick, len;
		logic [CH_W-1:0] ch;
		logic [OP_W-1:0] op;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			len  = (n_classes > 0) ? cls_len[n_classes-1] : 0;
			ch   = ($urandom_range(0, 3) == 0) ? CH_W'($urandom_range(0, 15))
			                                   : CH_W'($urandom_range(0, 255));
			// reuse a stored character now and then to hit duplicates
			if (len > 0 && $urandom_range(0, 99) < 20)
				ch = char_mem[cls_start[n_classes-1] + $urandom_range(0, len - 1)];
			if (n_classes == 0 || (pick < 6 && n_classes < CREATE_CAP))
				send_class_op(class_req(OP_CREATE, $urandom_range(0, 127),
					$urandom_range(0, 255)));
			else if (pick < 70)
				send_class_op(class_req(OP_ADD, n_classes, ch));
			else if (pick < 80)
				send_class_op(class_req(OP_NEGATE, $urandom_range(1, n_classes), ch));
			else if (pick < 87)
				send_class_op(class_req(OP_ADD, $urandom_range(1, n_classes), ch));
			else begin
				case ($urandom_range(0, 2))
					0: op = OP_ADD;
					1: op = OP_NEGATE;
					default: op = OP_UNUSED;
				endcase
				send_class_op(class_req(op, $urandom_range(0, 127), ch));
			end
		end
		drain_results();
	endtask

	// Receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		-> hold_kick;
		repeat (10)
			send_class_op(class_req(OP_ADD, n_classes, $urandom_range(0, 255)));
		drain_results();
	endtask

	// Fill the character table, then add and create against a full table
	task automatic test_table_full();
		int unsigned     last, base, len;
		bit [CHARS-1:0]  used;
		logic [CH_W-1:0] ch;
		tx_idle_pct  = 28;
		rx_stall_pct = 28;
		while (cls_start[n_classes-1] + cls_len[n_classes-1] < DEPTH) begin
			last = n_classes;
			base = cls_start[last-1];
			len  = cls_len[last-1];
			if (len == CHARS) begin
				send_class_op(class_req(OP_CREATE, 0, 0));
			end else begin
				used = '0;
				for (int i = 0; i < len; i++)
					used[char_mem[base+i]] = 1'b1;
				ch = $urandom_range(0, 255);
				while (used[ch]) ch++;
				send_class_op(class_req(OP_ADD, last, ch));
			end
		end
		last = n_classes;
		base = cls_start[last-1];
		len  = cls_len[last-1];
		// duplicate in a full table, then an absent character if room is left in the class
		send_class_op(class_req(OP_ADD, last, char_mem[base]));
		if (len < CHARS) begin
			used = '0;
			for (int i = 0; i < len; i++)
				used[char_mem[base+i]] = 1'b1;
			ch = $urandom_range(0, 255);
			while (used[ch]) ch++;
			send_class_op(class_req(OP_ADD, last, ch));
		end
		// class created with its start at the end of the table
		send_class_op(class_req(OP_CREATE, 0, 0));
		send_class_op(class_req(OP_ADD, n_classes, 8'h7E));
		send_class_op(class_req(OP_NEGATE, n_classes, 0));
		drain_results();
	endtask

	// Create up to the class limit and past it
	task automatic test_class_limit();
		tx_idle_pct  = 0;
		rx_stall_pct = 71;
		while (n_classes < MAX_CLS)
			send_class_op(class_req(OP_CREATE, $urandom_range(0, 127), $urandom_range(0, 255)));
		repeat (2)
			send_class_op(class_req(OP_CREATE, 0, 0));
		send_class_op(class_req(OP_NEGATE, MAX_CLS, 0));
		send_class_op(class_req(OP_ADD, MAX_CLS, 8'h01));
		send_class_op(class_req(OP_ADD, MAX_CLS - 1, 8'h01));
		send_class_op(class_req(OP_ADD, MAX_CLS + 1, 8'h01));
		send_class_op(class_req(OP_NEGATE, 127, 0));
		drain_results();
	endtask

	// Test sequence
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_empty_store();
		test_basic_ops();
		test_random_traffic(0, 0);
		test_random_traffic(71, 0);
		test_random_traffic(0, 71);
		test_random_traffic(28, 28);
		test_backpressure();
		test_table_full();
		test_class_limit();
		$display("Run covered %0d items and %0d results, %0d classes, table filled to the end",
			items_sent, results_checked, n_classes);
		$display("Statuses seen: ok %0d, present %0d, full %0d, too many %0d, bad class %0d",
			status_seen[STS_OK], status_seen[STS_PRESENT], status_seen[STS_FULL],
			status_seen[STS_MANY], status_seen[STS_BAD]);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
src/ccss_pkg.sv
src/ccss_ram.sv
src/ccss_ctrl.sv
src/ccss_dp.sv
src/char_class_set_store_unit.sv
src/ccss_chk.sv
dv/char_class_set_store_unit_tb.sv
